// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion violated");

// Next-cycle implication, disabled while reset is asserted.
`define QAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion violated");

`endif

// ===== sv/qau_pkg.sv =====
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, codes and step tables of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qau_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 28;
	localparam int QUEUE_DEPTH    = 2;
	localparam int STEP_W         = 5;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_NORM = 3'd4,
		OP_MAT  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_DIV0  = 2'd1,
		ERR_NORM0 = 2'd2
	} err_t;

	// job class decided by the front end
	typedef enum logic [2:0] {
		CLS_ADD  = 3'd0,
		CLS_SUB  = 3'd1,
		CLS_MUL  = 3'd2,
		CLS_DIV  = 3'd3,
		CLS_NORM = 3'd4,
		CLS_MAT  = 3'd5,
		CLS_ZERO = 3'd6
	} cls_t;

	typedef struct packed {
		cls_t cls;
		err_t err;
	} qctl_t;

	// one multiply-accumulate step
	typedef struct packed {
		logic [1:0] ia;
		logic [1:0] ib;
		logic       b_from_a;
		logic       neg;
		logic       dbl;
		logic       add_one;
		logic       first;
		logic       last;
		logic       to_sum;
		logic [3:0] dest;
	} term_t;

	function automatic logic [STEP_W-1:0] macc_steps(input cls_t c);
		case (c)
			CLS_MUL:  return STEP_W'(16);
			CLS_NORM: return STEP_W'(4);
			CLS_MAT:  return STEP_W'(18);
			default:  return '0;
		endcase
	endfunction

	function automatic term_t term_of(input cls_t c, input logic [STEP_W-1:0] s);
		term_t      t;
		logic [1:0] grp;
		logic [1:0] k;
		logic [3:0] e;
		t   = '0;
		grp = s[3:2];
		k   = s[1:0];
		e   = s[4:1];
		case (c)
			CLS_MUL: begin
				// Hamilton product: b index is a index xor output component
				t.ia    = k;
				t.ib    = k ^ grp;
				t.first = (k == 2'd0);
				t.last  = (k == 2'd3);
				t.dest  = {2'b00, grp};
				case (grp)
					2'd0:    t.neg = (k != 2'd0);
					2'd1:    t.neg = (k == 2'd3);
					2'd2:    t.neg = (k == 2'd1);
					default: t.neg = (k == 2'd2);
				endcase
			end
			CLS_NORM: begin
				t.ia       = k;
				t.ib       = k;
				t.b_from_a = 1'b1;
				t.first    = (k == 2'd0);
				t.last     = (k == 2'd3);
				t.to_sum   = 1'b1;
			end
			CLS_MAT: begin
				t.b_from_a = 1'b1;
				t.dbl      = 1'b1;
				t.first    = !s[0];
				t.last     = s[0];
				t.dest     = e;
				case (e)
					4'd0: begin
						t.add_one = 1'b1;
						t.ia = s[0] ? 2'd3 : 2'd2; t.ib = t.ia; t.neg = 1'b1;
					end
					4'd1: begin
						t.ia = s[0] ? 2'd0 : 2'd1; t.ib = s[0] ? 2'd3 : 2'd2; t.neg = s[0];
					end
					4'd2: begin
						t.ia = s[0] ? 2'd0 : 2'd1; t.ib = s[0] ? 2'd2 : 2'd3; t.neg = 1'b0;
					end
					4'd3: begin
						t.ia = s[0] ? 2'd0 : 2'd1; t.ib = s[0] ? 2'd3 : 2'd2; t.neg = 1'b0;
					end
					4'd4: begin
						t.add_one = 1'b1;
						t.ia = s[0] ? 2'd3 : 2'd1; t.ib = t.ia; t.neg = 1'b1;
					end
					4'd5: begin
						t.ia = s[0] ? 2'd0 : 2'd2; t.ib = s[0] ? 2'd1 : 2'd3; t.neg = s[0];
					end
					4'd6: begin
						t.ia = s[0] ? 2'd0 : 2'd1; t.ib = s[0] ? 2'd2 : 2'd3; t.neg = s[0];
					end
					4'd7: begin
						t.ia = s[0] ? 2'd0 : 2'd2; t.ib = s[0] ? 2'd1 : 2'd3; t.neg = 1'b0;
					end
					default: begin
						t.add_one = 1'b1;
						t.ia = s[0] ? 2'd2 : 2'd1; t.ib = t.ia; t.neg = 1'b1;
					end
				endcase
			end
			default: ;
		endcase
		return t;
	endfunction

endpackage

// ===== sv/qau_front.sv =====
// ----------------------------------------------------------------------------
// qau_front
// Accepts input beats, classifies the opcode and queues jobs for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qau_front #(
	parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic [2:0]              opcode,
	input  logic [DATA_WIDTH-1:0]   a_w,
	input  logic [DATA_WIDTH-1:0]   a_x,
	input  logic [DATA_WIDTH-1:0]   a_y,
	input  logic [DATA_WIDTH-1:0]   a_z,
	input  logic [DATA_WIDTH-1:0]   b_w,
	input  logic [DATA_WIDTH-1:0]   b_x,
	input  logic [DATA_WIDTH-1:0]   b_y,
	input  logic [DATA_WIDTH-1:0]   b_z,
	input  logic [DATA_WIDTH-1:0]   divisor,
	input  logic                    pop,
	output logic                    head_valid,
	output qau_pkg::qctl_t          head_ctl,
	output logic [9*DATA_WIDTH-1:0] head_data
);
	import qau_pkg::*;

	localparam int W     = DATA_WIDTH;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	qctl_t              ctl_mem  [QUEUE_DEPTH];
	logic [9*W-1:0]     data_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	qctl_t              ctl_in;
	logic               push;

	always_comb begin
		ctl_in.err = ERR_OK;
		case (op_t'(opcode))
			OP_ADD:  ctl_in.cls = CLS_ADD;
			OP_SUB:  ctl_in.cls = CLS_SUB;
			OP_MUL:  ctl_in.cls = CLS_MUL;
			OP_DIV: begin
				if (divisor == '0) begin
					ctl_in.cls = CLS_ZERO;
					ctl_in.err = ERR_DIV0;
				end else begin
					ctl_in.cls = CLS_DIV;
				end
			end
			OP_NORM: ctl_in.cls = CLS_NORM;
			OP_MAT:  ctl_in.cls = CLS_MAT;
			default: ctl_in.cls = CLS_ZERO;
		endcase
	end

	assign item_stall = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign push       = item_valid && !item_stall;
	assign head_valid = (cnt_q != '0);
	assign head_ctl   = ctl_mem[rd_ptr_q];
	assign head_data  = data_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ctl_mem[wr_ptr_q]  <= ctl_in;
			data_mem[wr_ptr_q] <= {divisor, b_z, b_y, b_x, b_w, a_z, a_y, a_x, a_w};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

// ===== sv/qau_back.sv =====
// ----------------------------------------------------------------------------
// qau_back
// Executes queued jobs: shared multiplier with accumulator, square root,
// four divider lanes, and the output buffer that emits result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qau_back #(
	parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  qau_pkg::qctl_t          head_ctl,
	input  logic [9*DATA_WIDTH-1:0] head_data,
	output logic                    pop,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [DATA_WIDTH-1:0]   res0,
	output logic [DATA_WIDTH-1:0]   res1,
	output logic [DATA_WIDTH-1:0]   res2,
	output logic [DATA_WIDTH-1:0]   res3,
	output logic [1:0]              row_index,
	output logic                    last,
	output logic [1:0]              error_code
);
	import qau_pkg::*;

	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * W;
	localparam int AW  = 2 * W + 3;
	localparam int SW  = 2 * W + 2;
	localparam int RW  = W + 1;
	localparam int DVW = W + 1;
	localparam int NW  = W + F;
	localparam int CW  = $clog2(NW + 1);
	localparam logic [AW-1:0] ONE  = AW'(1) << (2 * F);
	localparam logic [W-1:0]  SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  SMIN = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MACC = 5'b00010,
		S_SQRT = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	function automatic logic [W-1:0] pick(input logic [1:0] i, input logic [4*W-1:0] v);
		return v[i*W +: W];
	endfunction

	function automatic logic [W-1:0] addsub(input logic [W-1:0] x, input logic [W-1:0] y,
	                                        input logic sub);
		logic [W:0] s;
		s = sub ? ({x[W-1], x} - {y[W-1], y}) : ({x[W-1], x} + {y[W-1], y});
		if (s[W] == s[W-1])
			return s[W-1:0];
		return s[W] ? SMIN : SMAX;
	endfunction

	function automatic logic [W-1:0] fin(input logic [AW-1:0] v);
		logic [AW-1:0] sh;
		sh = $signed(v) >>> F;
		if (sh[AW-1:W-1] == {(AW-W+1){sh[AW-1]}})
			return sh[W-1:0];
		return sh[AW-1] ? SMIN : SMAX;
	endfunction

	function automatic logic [W-1:0] sat_div(input logic [NW-1:0] q, input logic neg);
		logic hi_zero;
		hi_zero = (q[NW-1:W] == '0);
		if (neg) begin
			if (hi_zero && (!q[W-1] || q[W-2:0] == '0))
				return W'(-q[W-1:0]);
			return SMIN;
		end
		if (hi_zero && !q[W-1])
			return q[W-1:0];
		return SMAX;
	endfunction

	state_t          st_q;
	logic [CW-1:0]   cnt_q;
	cls_t            cls_q;
	err_t            err_q;
	logic [4*W-1:0]  a_q;
	logic [4*W-1:0]  b_q;
	logic [W-1:0]    res_q [9];

	// multiply-accumulate pipeline
	term_t           term_c;
	logic            issue;
	logic [W-1:0]    op_a;
	logic [W-1:0]    op_b;
	logic            v_s1;
	term_t           tag_s1;
	logic [PW-1:0]   prod_s1;
	logic [AW-1:0]   acc_q;
	logic [AW-1:0]   addend;
	logic [AW-1:0]   base;
	logic [AW-1:0]   acc_n;
	logic [SW-1:0]   sum_q;
	logic            sum_zero;

	// square root
	logic [SW-1:0]   sq_src_q;
	logic [RW+1:0]   sq_rem_q;
	logic [RW-1:0]   root_q;
	logic [RW+3:0]   sq_rt;
	logic [RW+3:0]   sq_trial;
	logic [RW+3:0]   sq_diff;
	logic            sq_ge;
	logic [RW+1:0]   sq_rem_n;
	logic [RW-1:0]   root_n;

	// divider lanes
	logic [DVW-1:0]  dv_q;
	logic [NW-1:0]   num_q  [4];
	logic [DVW-1:0]  rem_q  [4];
	logic            qneg_q [4];
	logic [NW-1:0]   num_n  [4];
	logic [DVW-1:0]  rem_n  [4];
	logic [DVW:0]    dv_raw [4];
	logic [DVW:0]    dv_dif [4];
	logic            ld_lanes;
	logic [4*W-1:0]  ld_src;
	logic [DVW-1:0]  ld_dv;
	logic            ld_dneg;
	logic [W-1:0]    head_d;
	logic [W-1:0]    abs_d;
	logic [W-1:0]    ld_comp [4];
	logic [W-1:0]    ld_mag  [4];

	// output buffer
	logic            ob_valid_q;
	logic [1:0]      ob_row_q;
	logic            ob_mat_q;
	err_t            ob_err_q;
	logic [W-1:0]    ob_q [9];
	logic            take;
	logic            ob_last;
	logic            ob_free;

	assign pop = (st_q == S_IDLE) && head_valid;

	// ---- issue side of the multiplier
	always_comb begin
		term_c = term_of(cls_q, cnt_q[STEP_W-1:0]);
		op_a   = pick(term_c.ia, a_q);
		op_b   = term_c.b_from_a ? pick(term_c.ib, a_q) : pick(term_c.ib, b_q);
		issue  = (st_q == S_MACC) && (cnt_q < CW'(macc_steps(cls_q)));
	end

	// ---- accumulate side
	always_comb begin
		addend = {{(AW-PW){prod_s1[PW-1]}}, prod_s1};
		if (tag_s1.dbl)
			addend = addend << 1;
		if (tag_s1.first)
			base = tag_s1.add_one ? ONE : '0;
		else
			base = acc_q;
		acc_n = tag_s1.neg ? (base - addend) : (base + addend);
	end

	assign sum_zero = (sum_q == '0);

	// ---- square root step, one root bit per cycle
	always_comb begin
		sq_rt    = {sq_rem_q, sq_src_q[SW-1 -: 2]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_ge    = (sq_rt >= sq_trial);
		sq_diff  = sq_rt - sq_trial;
		sq_rem_n = sq_ge ? sq_diff[RW+1:0] : sq_rt[RW+1:0];
		root_n   = {root_q[RW-2:0], sq_ge};
	end

	// ---- divider lanes, one quotient bit per cycle each
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			dv_raw[l] = {rem_q[l], num_q[l][NW-1]};
			dv_dif[l] = dv_raw[l] - {1'b0, dv_q};
			if (dv_raw[l] >= {1'b0, dv_q}) begin
				rem_n[l] = dv_dif[l][DVW-1:0];
				num_n[l] = {num_q[l][NW-2:0], 1'b1};
			end else begin
				rem_n[l] = dv_raw[l][DVW-1:0];
				num_n[l] = {num_q[l][NW-2:0], 1'b0};
			end
		end
	end

	// lanes load from the queue head (divide) or from the finished root (normalize)
	always_comb begin
		head_d   = head_data[8*W +: W];
		abs_d    = head_d[W-1] ? W'(-head_d) : head_d;
		ld_lanes = (pop && head_ctl.cls == CLS_DIV) ||
		           (st_q == S_SQRT && cnt_q == CW'(RW));
		ld_src   = pop ? head_data[4*W-1:0] : a_q;
		ld_dv    = pop ? {1'b0, abs_d} : root_n;
		ld_dneg  = pop ? head_d[W-1] : 1'b0;
		for (int l = 0; l < 4; l++) begin
			ld_comp[l] = ld_src[l*W +: W];
			ld_mag[l]  = ld_comp[l][W-1] ? W'(-ld_comp[l]) : ld_comp[l];
		end
	end

	// ---- output side
	assign take    = ob_valid_q && !result_stall;
	assign ob_last = !ob_mat_q || (ob_row_q == 2'd2);
	assign ob_free = !ob_valid_q || (take && ob_last);

	assign result_valid = ob_valid_q;
	assign res0         = ob_q[0];
	assign res1         = ob_q[1];
	assign res2         = ob_q[2];
	assign res3         = ob_mat_q ? '0 : ob_q[3];
	assign row_index    = ob_row_q;
	assign last         = ob_last;
	assign error_code   = ob_err_q;

	// ---- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			cnt_q      <= '0;
			v_s1       <= 1'b0;
			ob_valid_q <= 1'b0;
			ob_row_q   <= '0;
		end else begin
			v_s1 <= issue;
			case (st_q)
				S_IDLE: begin
					if (head_valid) begin
						cnt_q <= '0;
						case (head_ctl.cls)
							CLS_ADD, CLS_SUB, CLS_ZERO: st_q <= S_DONE;
							CLS_DIV:                    st_q <= S_DIV;
							default:                    st_q <= S_MACC;
						endcase
					end
				end
				S_MACC: begin
					if (cnt_q == CW'(macc_steps(cls_q))) begin
						cnt_q <= '0;
						st_q  <= (cls_q == CLS_NORM) ? S_SQRT : S_DONE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_SQRT: begin
					if (cnt_q == '0) begin
						if (sum_zero)
							st_q <= S_DONE;
						else
							cnt_q <= CW'(1);
					end else if (cnt_q == CW'(RW)) begin
						cnt_q <= '0;
						st_q  <= S_DIV;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_DIV: begin
					if (cnt_q == CW'(NW - 1)) begin
						cnt_q <= '0;
						st_q  <= S_DONE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_DONE: begin
					if (ob_free)
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase

			if (st_q == S_DONE && ob_free) begin
				ob_valid_q <= 1'b1;
				ob_row_q   <= '0;
			end else if (take) begin
				if (ob_last)
					ob_valid_q <= 1'b0;
				else
					ob_row_q <= ob_row_q + 2'd1;
			end
		end
	end

	// ---- datapath
	always_ff @(posedge clk) begin
		prod_s1 <= PW'($signed(op_a) * $signed(op_b));
		tag_s1  <= term_c;

		if (pop) begin
			a_q   <= head_data[4*W-1:0];
			b_q   <= head_data[8*W-1:4*W];
			cls_q <= head_ctl.cls;
			err_q <= head_ctl.err;
			for (int i = 0; i < 4; i++) begin
				case (head_ctl.cls)
					CLS_ADD: res_q[i] <= addsub(head_data[i*W +: W],
					                            head_data[(4+i)*W +: W], 1'b0);
					CLS_SUB: res_q[i] <= addsub(head_data[i*W +: W],
					                            head_data[(4+i)*W +: W], 1'b1);
					CLS_ZERO: res_q[i] <= '0;
					default: ;
				endcase
			end
		end

		if (v_s1) begin
			acc_q <= acc_n;
			if (tag_s1.last) begin
				if (tag_s1.to_sum)
					sum_q <= acc_n[SW-1:0];
				else
					res_q[tag_s1.dest] <= fin(acc_n);
			end
		end

		if (st_q == S_SQRT) begin
			if (cnt_q == '0) begin
				sq_src_q <= sum_q;
				sq_rem_q <= '0;
				root_q   <= '0;
				if (sum_zero) begin
					err_q <= ERR_NORM0;
					for (int i = 0; i < 4; i++)
						res_q[i] <= '0;
				end
			end else begin
				sq_src_q <= sq_src_q << 2;
				sq_rem_q <= sq_rem_n;
				root_q   <= root_n;
			end
		end

		if (ld_lanes) begin
			dv_q <= ld_dv;
			for (int l = 0; l < 4; l++) begin
				num_q[l]  <= {ld_mag[l], {F{1'b0}}};
				rem_q[l]  <= '0;
				qneg_q[l] <= ld_comp[l][W-1] ^ ld_dneg;
			end
		end else if (st_q == S_DIV) begin
			for (int l = 0; l < 4; l++) begin
				num_q[l] <= num_n[l];
				rem_q[l] <= rem_n[l];
				if (cnt_q == CW'(NW - 1))
					res_q[l] <= sat_div(num_n[l], qneg_q[l]);
			end
		end

		if (st_q == S_DONE && ob_free) begin
			for (int i = 0; i < 9; i++)
				ob_q[i] <= res_q[i];
			ob_mat_q <= (cls_q == CLS_MAT);
			ob_err_q <= err_q;
		end else if (take && !ob_last) begin
			// matrix: move the next row down to the output places
			for (int i = 0; i < 6; i++)
				ob_q[i] <= ob_q[i+3];
		end
	end

endmodule

// ===== sv/quaternion_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Signed fixed-point quaternion unit: add, subtract, Hamilton product,
// scalar divide, normalize, and conversion to a rotation matrix.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  item    | item_valid / item_stall   | opcode, a_w..a_z, b_w..b_z, divisor
//  result  | result_valid/result_stall | res0..res3, row_index, last, error_code
//
//  Steps per item in the back end (one job at a time):
//    add, subtract, divide by zero, spare opcodes: straight to the output;
//    multiply: multiply-accumulate; rotation matrix: multiply-accumulate,
//    then three result beats; divide: the one-bit-per-cycle divider lanes;
//    normalize: multiply-accumulate, square root, then the divider lanes
//    (a zero norm ends after the multiply-accumulate and the root check).
//  The front end queues two jobs, so input beats are taken while the back end
//  works. The output buffer lets the next job compute while a result waits;
//  that job then holds in its final cycle until the buffer frees.
//  Reset is asynchronous and clears the queue, sequencer and output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_arithmetic_unit #(
	parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [2:0]            opcode,
	input  logic [DATA_WIDTH-1:0] a_w,
	input  logic [DATA_WIDTH-1:0] a_x,
	input  logic [DATA_WIDTH-1:0] a_y,
	input  logic [DATA_WIDTH-1:0] a_z,
	input  logic [DATA_WIDTH-1:0] b_w,
	input  logic [DATA_WIDTH-1:0] b_x,
	input  logic [DATA_WIDTH-1:0] b_y,
	input  logic [DATA_WIDTH-1:0] b_z,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [DATA_WIDTH-1:0] res0,
	output logic [DATA_WIDTH-1:0] res1,
	output logic [DATA_WIDTH-1:0] res2,
	output logic [DATA_WIDTH-1:0] res3,
	output logic [1:0]            row_index,
	output logic                  last,
	output logic [1:0]            error_code
);
	import qau_pkg::*;

	// queue head between the front and back ends
	logic                    head_valid;
	qctl_t                   head_ctl;
	logic [9*DATA_WIDTH-1:0] head_data;
	logic                    pop;

	// front end: classification (illegal opcode, divide by zero) and job queue
	qau_front #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.opcode     (opcode),
		.a_w        (a_w),
		.a_x        (a_x),
		.a_y        (a_y),
		.a_z        (a_z),
		.b_w        (b_w),
		.b_x        (b_x),
		.b_y        (b_y),
		.b_z        (b_z),
		.divisor    (divisor),
		.pop        (pop),
		.head_valid (head_valid),
		.head_ctl   (head_ctl),
		.head_data  (head_data)
	);

	// back end: multiply-accumulate, square root, divider lanes, output buffer
	qau_back #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_ctl     (head_ctl),
		.head_data    (head_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.res0         (res0),
		.res1         (res1),
		.res2         (res2),
		.res3         (res3),
		.row_index    (row_index),
		.last         (last),
		.error_code   (error_code)
	);

endmodule

// ===== sv/qau_checker.sv =====
// ----------------------------------------------------------------------------
// qau_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qau_checker #(
	parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  result_valid,
	input logic                  result_stall,
	input logic [DATA_WIDTH-1:0] res0,
	input logic [DATA_WIDTH-1:0] res1,
	input logic [DATA_WIDTH-1:0] res2,
	input logic [DATA_WIDTH-1:0] res3,
	input logic [1:0]            row_index,
	input logic                  last,
	input logic [1:0]            error_code
);
	import qau_pkg::*;

	// a stalled beat holds
	`QAU_ASSERT_NXT(a_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(res0) && $stable(res1) && $stable(res2) && $stable(row_index) && $stable(last))

	// error results are a single all-zero beat
	`QAU_ASSERT_IMP(a_err_zero, clk, arst_n, result_valid && error_code != ERR_OK, last && row_index == 2'd0 && res0 == '0 && res1 == '0 && res2 == '0 && res3 == '0)

	// the third matrix row closes the item
	`QAU_ASSERT_IMP(a_row_end, clk, arst_n, result_valid && row_index == 2'd2, last && res3 == '0 && error_code == ERR_OK)

	// a matrix row that is not the last is followed at once by the next one
	`QAU_ASSERT_NXT(a_row_next, clk, arst_n, result_valid && !result_stall && !last, result_valid)

endmodule

bind quaternion_arithmetic_unit qau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qau_checker (.*);
